>>> rtl/ght_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle table package
// Shared word types, command and status codes, and sizing constants.
// ----------------------------------------------------------------------------
package ght_pkg;

    // Default number of slots in the table.
    localparam int SLOT_COUNT_DEF = 64;

    // Handle layout: generation in the upper half, slot index plus one below.
    localparam int GEN_W     = 16;
    localparam int GEN_SHIFT = 16;
    localparam logic [GEN_W-1:0] GEN_MASK = 16'hffff;
    localparam logic [GEN_W-1:0] GEN_INIT = 16'h0001;

    // Live bits are packed this many to a memory word.
    localparam int LIVE_WORD_W = 32;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_CHECK = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] handle_in;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [1:0]  status;
        logic [31:0] handle_out;
        logic [5:0]  slot_index;
        logic [31:0] serial_id;
        logic [6:0]  live_count;
    } t_rsp;

    // One slot entry as held in memory.
    typedef struct packed {
        logic [GEN_W-1:0] gen;
        logic [31:0]      serial;
    } t_entry;

endpackage

>>> rtl/ght_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ght_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/generational_handle_table_top.sv
// ----------------------------------------------------------------------------
// Generational handle table
// Fixed table of slots that hands out and checks generation-tagged handles.
// ----------------------------------------------------------------------------
// Usage. The request channel (i_in_valid, o_in_stall, i_in) carries one word
// per command: allocate, validate or release. The response channel
// (o_out_valid, i_out_stall, o_out) returns exactly one word per request, in
// order. A word moves on a rising edge with valid high and stall low.
//
// Sequencing. A command runs under a small sequencer that shares one read port on
// each of two memories: a live-bit memory packed 32 slots to a word and a slot
// entry memory holding generation and serial. Validate and release read the
// live word, then the slot entry. Allocate scans the live words one read at a
// time for the lowest free slot, then reads its entry; a full table answers
// after the last live word. A handle with a bad index part or an unused
// command goes straight to the done state. The next request is taken once the
// response is registered and the sequencer is back in idle.
//
// Reset. After reset a clearing pass writes every slot entry (generation 1)
// and every live word (all free) with o_in_stall high. If the receiver
// stalls, the response holds in the output register and a finished command
// waits in its done state until that register frees up.
// ----------------------------------------------------------------------------
module generational_handle_table_top #(
    parameter int SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ght_pkg::t_req i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ght_pkg::t_rsp o_out
);

    import ght_pkg::*;

    localparam int SLOT_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int LIVE_W    = $clog2(SLOT_COUNT + 1);
    localparam int LWORDS    = (SLOT_COUNT + LIVE_WORD_W - 1) / LIVE_WORD_W;
    localparam int LW_AW     = (LWORDS > 1) ? $clog2(LWORDS) : 1;
    localparam int BIT_W     = $clog2(LIVE_WORD_W);
    localparam int LAST_BITS = SLOT_COUNT - (LWORDS - 1) * LIVE_WORD_W;
    localparam int ENT_W     = $bits(t_entry);

    // Slots that exist in the last live word; the rest read as taken.
    localparam logic [LIVE_WORD_W-1:0] LAST_MASK =
        LIVE_WORD_W'((64'h1 << LAST_BITS) - 64'h1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_LREAD = 7'b0000100,
        S_LTEST = 7'b0001000,
        S_EREAD = 7'b0010000,
        S_ETEST = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                  r_state, n_state;
    logic [1:0]              r_cmd, n_cmd;
    logic [31:0]             r_handle, n_handle;
    logic [LW_AW-1:0]        r_word, n_word;
    logic [BIT_W-1:0]        r_bit, n_bit;
    logic [SLOT_W-1:0]       r_slot, n_slot;
    logic [LIVE_WORD_W-1:0]  r_lword, n_lword;
    logic [LIVE_W-1:0]       r_live, n_live;
    logic [31:0]             r_serial, n_serial;
    logic [SLOT_W-1:0]       r_clr, n_clr;
    t_rsp                    r_res, n_res;
    t_rsp                    r_out;
    logic                    r_out_valid;

    logic                    live_we;
    logic [LW_AW-1:0]        live_waddr;
    logic [LIVE_WORD_W-1:0]  live_wdata;
    logic [LIVE_WORD_W-1:0]  live_rdata;
    logic                    ent_we;
    logic [SLOT_W-1:0]       ent_waddr;
    t_entry                  ent_wdata;
    t_entry                  ent_rdata;
    logic                    out_free;

    ght_ram #(
        .WIDTH (LIVE_WORD_W),
        .DEPTH (LWORDS)
    ) u_live_ram (
        .i_clk   (i_clk),
        .i_we    (live_we),
        .i_waddr (live_waddr),
        .i_wdata (live_wdata),
        .i_raddr (r_word),
        .o_rdata (live_rdata)
    );

    ght_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOT_COUNT)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (r_slot),
        .o_rdata (ent_rdata)
    );

    // Lowest clear bit of a live word; the caller makes sure one exists.
    function automatic logic [BIT_W-1:0] lowest_free(input logic [LIVE_WORD_W-1:0] w);
        logic [BIT_W-1:0] f;
        f = '0;
        for (int j = LIVE_WORD_W - 1; j >= 0; j--) begin
            if (!w[j]) begin
                f = BIT_W'(j);
            end
        end
        return f;
    endfunction

    function automatic t_rsp make_rsp(input logic ok, input logic [1:0] status,
                                      input logic [31:0] handle,
                                      input logic [SLOT_W-1:0] slot,
                                      input logic [31:0] serial,
                                      input logic [LIVE_W-1:0] live);
        t_rsp r;
        r.ok         = ok;
        r.status     = status;
        r.handle_out = handle;
        r.slot_index = 6'(slot);
        r.serial_id  = serial;
        r.live_count = 7'(live);
        return r;
    endfunction

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        logic [15:0]            code;
        logic [15:0]            idx16;
        logic [15:0]            slot16;
        logic [LIVE_WORD_W-1:0] pad;
        logic [LIVE_WORD_W-1:0] masked;
        logic [BIT_W-1:0]       fbit;
        logic                   hit;
        logic [GEN_W-1:0]       gen_next;

        n_state    = r_state;
        n_cmd      = r_cmd;
        n_handle   = r_handle;
        n_word     = r_word;
        n_bit      = r_bit;
        n_slot     = r_slot;
        n_lword    = r_lword;
        n_live     = r_live;
        n_serial   = r_serial;
        n_clr      = r_clr;
        n_res      = r_res;
        live_we    = 1'b0;
        live_waddr = r_word;
        live_wdata = r_lword;
        ent_we     = 1'b0;
        ent_waddr  = r_slot;
        ent_wdata  = ent_rdata;

        code     = i_in.handle_in[15:0];
        idx16    = code - 16'd1;
        pad      = (r_word == LW_AW'(LWORDS - 1)) ? ~LAST_MASK : '0;
        masked   = live_rdata | pad;
        fbit     = lowest_free(masked);
        slot16   = (16'(r_word) << BIT_W) | 16'(fbit);
        hit      = r_lword[r_bit] && (ent_rdata.gen == r_handle[31:GEN_SHIFT]);
        gen_next = (ent_rdata.gen >= GEN_MASK) ? GEN_INIT : ent_rdata.gen + GEN_INIT;

        case (r_state)
            S_CLEAR: begin
                ent_we         = 1'b1;
                ent_waddr      = r_clr;
                ent_wdata.gen  = GEN_INIT;
                ent_wdata.serial = '0;
                if (16'(r_clr) < 16'(LWORDS)) begin
                    live_we    = 1'b1;
                    live_waddr = LW_AW'(r_clr);
                    live_wdata = '0;
                end
                if (16'(r_clr) == 16'(SLOT_COUNT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + SLOT_W'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_in.cmd;
                    n_handle = i_in.handle_in;
                    case (i_in.cmd)
                        CMD_ALLOC: begin
                            n_word  = '0;
                            n_state = S_LREAD;
                        end
                        CMD_CHECK, CMD_FREE: begin
                            if (code != 16'd0 && 32'(code) <= SLOT_COUNT) begin
                                n_slot  = idx16[SLOT_W-1:0];
                                n_word  = LW_AW'(idx16 >> BIT_W);
                                n_bit   = idx16[BIT_W-1:0];
                                n_state = S_LREAD;
                            end else begin
                                n_res   = make_rsp(1'b0, ST_BAD, '0, '0, '0, r_live);
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_res   = make_rsp(1'b0, ST_BAD, '0, '0, '0, r_live);
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_LREAD: begin
                n_state = S_LTEST;
            end
            S_LTEST: begin
                n_lword = live_rdata;
                if (r_cmd == CMD_ALLOC) begin
                    if (masked != '1) begin
                        n_bit   = fbit;
                        n_slot  = slot16[SLOT_W-1:0];
                        n_state = S_EREAD;
                    end else if (r_word == LW_AW'(LWORDS - 1)) begin
                        n_res   = make_rsp(1'b0, ST_FULL, '0, '0, '0, r_live);
                        n_state = S_DONE;
                    end else begin
                        n_word  = r_word + LW_AW'(1);
                        n_state = S_LREAD;
                    end
                end else begin
                    n_state = S_EREAD;
                end
            end
            S_EREAD: begin
                n_state = S_ETEST;
            end
            S_ETEST: begin
                n_state = S_DONE;
                case (r_cmd)
                    CMD_ALLOC: begin
                        n_serial         = r_serial + 32'd1;
                        n_live           = r_live + LIVE_W'(1);
                        ent_we           = 1'b1;
                        ent_wdata.serial = n_serial;
                        live_we          = 1'b1;
                        live_wdata       = r_lword | (LIVE_WORD_W'(1) << r_bit);
                        n_res = make_rsp(1'b1, ST_OK,
                                         {ent_rdata.gen, 16'(r_slot) + 16'd1},
                                         r_slot, n_serial, n_live);
                    end
                    CMD_FREE: begin
                        if (hit) begin
                            ent_we        = 1'b1;
                            ent_wdata.gen = gen_next;
                            live_we       = 1'b1;
                            live_wdata    = r_lword & ~(LIVE_WORD_W'(1) << r_bit);
                            if (r_live != '0) begin
                                n_live = r_live - LIVE_W'(1);
                            end
                            n_res = make_rsp(1'b1, ST_OK, r_handle, r_slot,
                                             ent_rdata.serial, n_live);
                        end else begin
                            n_res = make_rsp(1'b0, ST_BAD, '0, '0, '0, r_live);
                        end
                    end
                    default: begin
                        if (hit) begin
                            n_res = make_rsp(1'b1, ST_OK, r_handle, r_slot,
                                             ent_rdata.serial, r_live);
                        end else begin
                            n_res = make_rsp(1'b0, ST_BAD, '0, '0, '0, r_live);
                        end
                    end
                endcase
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_live      <= '0;
            r_serial    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_live   <= n_live;
            r_serial <= n_serial;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_handle <= n_handle;
        r_word   <= n_word;
        r_bit    <= n_bit;
        r_slot   <= n_slot;
        r_lword  <= n_lword;
        r_res    <= n_res;
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The clearing pass must finish before any request is taken.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_in_stall)
        else $error("request accepted during clearing pass");

    // A generation of zero would let a zero-generation handle match.
    a_gen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ent_we |-> (ent_wdata.gen != '0))
        else $error("slot generation written as zero");

    // An allocation that reaches the entry stage always claims a slot.
    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ETEST && r_cmd == CMD_ALLOC) |=>
            (r_live == $past(r_live) + LIVE_W'(1)))
        else $error("allocation did not advance the live count");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_live) <= SLOT_COUNT)
        else $error("live count exceeds table size");

    // A successful response always carries a handle with a nonzero index part.
    a_ok_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.ok) |->
            (o_out.status == ST_OK && o_out.handle_out[15:0] != 16'd0))
        else $error("successful response with bad status or handle");

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// Generational handle table testbench
// Drives allocate, validate and release words into the table, keeps its own
// model of the slot table to predict every response word, and checks each
// response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import ght_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;

    // The package names three commands; the fourth code is unused and must be
    // rejected as a bad request.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // The slot table is kept in two views. The accepted view advances when the
    // block takes a request word and produces the predictions. The plan view
    // advances while the stimulus is built, so that the generator knows which
    // handles are live and which have gone stale.
    localparam int ACCEPTED_VIEW = 0;
    localparam int PLAN_VIEW     = 1;

    // One queued request word, with a flag that holds it back until every
    // outstanding response has come home, and a flag that turns idling off.
    typedef struct packed {
        logic drain_first;
        logic calm;
        t_req word;
    } t_stim;

    logic  i_clk;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    t_req  i_in        = '0;
    logic  i_out_stall = 1'b0;
    logic  o_in_stall;
    logic  o_out_valid;
    t_rsp  o_out;

    // Slot table state, one copy per view.
    bit          slot_used   [2][SLOTS];
    logic [15:0] slot_gen    [2][SLOTS];
    logic [31:0] slot_serial [2][SLOTS];
    logic [31:0] serial_ctr  [2];
    logic [6:0]  used_total  [2];

    t_stim       cmd_q[$];       // request words waiting to be driven
    t_rsp        due_rsp_q[$];   // predicted responses, oldest first
    logic [31:0] live_h[$];      // handles the plan view holds as live
    logic [31:0] stale_h[$];     // recently released handles

    int  err_cnt    = 0;
    int  gap_left   = 0;
    int  stall_left = 0;
    bit  word_taken = 1'b0;
    bit  calm_now   = 1'b0;

    generational_handle_table_top #(
        .SLOT_COUNT (SLOTS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or drops a response.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Applies one request to a view of the slot table and returns the response
    // the block must give. Allocate takes the lowest free slot; validate and
    // release need a nonzero index part inside the table, a live slot and a
    // matching generation. Release bumps the generation, skipping zero.
    function automatic t_rsp slot_table_step(input int v, input t_req req);
        t_rsp          rsp;
        logic [15:0]   code;
        logic [15:0]   tag;
        int unsigned   idx;
        bit            hit;
        rsp  = '0;
        code = req.handle_in[15:0];
        tag  = req.handle_in[31:16];
        idx  = 0;
        hit  = 1'b0;
        case (req.cmd)
            CMD_ALLOC: begin
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (!slot_used[v][i]) begin
                        hit = 1'b1;
                        idx = i;
                    end
                end
                if (hit) begin
                    slot_used[v][idx]   = 1'b1;
                    serial_ctr[v]       = serial_ctr[v] + 32'd1;
                    slot_serial[v][idx] = serial_ctr[v];
                    used_total[v]       = used_total[v] + 7'd1;
                    rsp.ok         = 1'b1;
                    rsp.status     = ST_OK;
                    rsp.handle_out = {slot_gen[v][idx], 16'(idx + 1)};
                    rsp.slot_index = 6'(idx);
                    rsp.serial_id  = slot_serial[v][idx];
                end else begin
                    rsp.status = ST_FULL;
                end
            end
            CMD_CHECK, CMD_FREE: begin
                hit = (code != 16'd0) && (code <= SLOTS);
                if (hit) begin
                    idx = code - 16'd1;
                    hit = slot_used[v][idx] && (slot_gen[v][idx] == tag);
                end
                if (hit) begin
                    if (req.cmd == CMD_FREE) begin
                        slot_used[v][idx] = 1'b0;
                        slot_gen[v][idx]  = (slot_gen[v][idx] == GEN_MASK) ? GEN_INIT
                                                                            : slot_gen[v][idx] + 16'd1;
                        if (used_total[v] != 7'd0) used_total[v] = used_total[v] - 7'd1;
                    end
                    rsp.ok         = 1'b1;
                    rsp.status     = ST_OK;
                    rsp.handle_out = req.handle_in;
                    rsp.slot_index = 6'(idx);
                    rsp.serial_id  = slot_serial[v][idx];
                end else begin
                    rsp.status = ST_BAD;
                end
            end
            default: begin
                rsp.status = ST_BAD;
            end
        endcase
        rsp.live_count = used_total[v];
        return rsp;
    endfunction

    // Queues one request word and runs it through the plan view, so that the
    // lists of live and stale handles follow the table.
    task automatic plan_item(input logic [1:0] cmd, input logic [31:0] handle,
                             input bit drain, input bit calm);
        t_req  req;
        t_rsp  rsp;
        t_stim s;
        int    hit_at;
        req.cmd       = cmd;
        req.handle_in = handle;
        rsp = slot_table_step(PLAN_VIEW, req);
        if (rsp.ok && cmd == CMD_ALLOC) live_h = {live_h, rsp.handle_out};
        if (rsp.ok && cmd == CMD_FREE) begin
            hit_at = -1;
            for (int k = 0; k < live_h.size(); k++) begin
                if (hit_at < 0 && live_h[k] == handle) hit_at = k;
            end
            if (hit_at >= 0) live_h.delete(hit_at);
            stale_h = {stale_h, handle};
            if (stale_h.size() > SLOTS) void'(stale_h.pop_front());
        end
        s.drain_first = drain;
        s.calm        = calm;
        s.word        = req;
        cmd_q = {cmd_q, s};
    endtask

    // Mostly handles the table really holds, some stale ones, and the rest
    // malformed or guessed: random bits, generation zero, index zero, beyond the table, or a small generation.
    function automatic logic [31:0] pick_handle();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14 && live_h.size() > 0) return live_h[$urandom_range(0, live_h.size() - 1)];
        if (r < 17 && stale_h.size() > 0) return stale_h[$urandom_range(0, stale_h.size() - 1)];
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return {16'h0000, 16'($urandom_range(1, SLOTS))};
            2:       return {16'($urandom), 16'h0000};
            3:       return {16'($urandom), 16'($urandom_range(SLOTS + 1, 65535))};
            default: return {16'($urandom_range(1, 3)), 16'($urandom_range(1, SLOTS))};
        endcase
    endfunction

    task automatic check_rsp(input t_rsp got, input t_rsp want);
        if (got.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, got.ok);
            err_cnt++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            err_cnt++;
        end
        if (got.handle_out !== want.handle_out) begin
            $error("handle_out: expected %h, got %h", want.handle_out, got.handle_out);
            err_cnt++;
        end
        if (got.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
            err_cnt++;
        end
        if (got.serial_id !== want.serial_id) begin
            $error("serial_id: expected %0d, got %0d", want.serial_id, got.serial_id);
            err_cnt++;
        end
        if (got.live_count !== want.live_count) begin
            $error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
            err_cnt++;
        end
    endtask

    // Monitor. Everything is sampled at the rising edge, before the block's own
    // updates land. The response is checked first, then an accepted request
    // word is predicted and its response queued.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (due_rsp_q.size() == 0) begin
                    $error("response word with none outstanding: handle_out %h",
                           o_out.handle_out);
                    err_cnt++;
                end else begin
                    check_rsp(o_out, due_rsp_q.pop_front());
                end
            end
            if (i_in_valid && !o_in_stall) begin
                due_rsp_q = {due_rsp_q, slot_table_step(ACCEPTED_VIEW, i_in)};
                word_taken = 1'b1;
            end
        end
    end

    // Driver. A word stays on the bus until it is taken. Between words it may
    // insert an idle gap, unless the word is marked calm. A word
    // marked drain_first is held back until no response is outstanding.
    always @(negedge i_clk) begin
        logic  send;
        t_stim nxt;
        send = 1'b0;
        if (i_rst_n && !(i_in_valid && !word_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_q.size() > 0) begin
                if (cmd_q[0].drain_first && due_rsp_q.size() > 0) begin
                    send = 1'b0;
                end else if (!cmd_q[0].calm && $urandom_range(0, 3) == 0) begin
                    gap_left = $urandom_range(0, 4);
                end else begin
                    send = 1'b1;
                end
            end
            if (send) begin
                nxt      = cmd_q.pop_front();
                calm_now = nxt.calm;
                i_in    <= nxt.word;
            end
            i_in_valid <= send;
        end
        word_taken = 1'b0;
    end

    // Receiver back-pressure: random bursts of stall, none started while calm
    // words are being sent.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!calm_now && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        int          n;
        int          len;
        int          bias;
        int          alloc_pct;
        int          r;
        int          wait_cnt;
        bit          calm;
        logic [1:0]  cmd;

        for (int v = 0; v < 2; v++) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[v][i]   = 1'b0;
                slot_gen[v][i]    = GEN_INIT;
                slot_serial[v][i] = 32'd0;
            end
            serial_ctr[v] = 32'd0;
            used_total[v] = 7'd0;
        end

        // Directed opening: rejects on an empty table, every command, the
        // malformed handle shapes, a stale handle after release, slot reuse at
        // the next generation, and draining back to an empty table.
        plan_item(CMD_CHECK,  {GEN_INIT, 16'd1},         1'b0, 1'b0);
        plan_item(CMD_FREE,   {GEN_INIT, 16'd0},         1'b0, 1'b0);
        plan_item(CMD_UNUSED, 32'hffff_ffff,             1'b0, 1'b0);
        plan_item(CMD_ALLOC,  32'hffff_ffff,             1'b0, 1'b0);
        plan_item(CMD_ALLOC,  32'h0000_0000,             1'b0, 1'b0);
        plan_item(CMD_ALLOC,  32'h5a5a_a5a5,             1'b0, 1'b0);
        plan_item(CMD_CHECK,  {GEN_INIT, 16'd1},         1'b0, 1'b0);
        plan_item(CMD_CHECK,  {16'd0, 16'd1},            1'b0, 1'b0);
        plan_item(CMD_CHECK,  {GEN_INIT, 16'(SLOTS + 1)}, 1'b0, 1'b0);
        plan_item(CMD_CHECK,  32'hffff_ffff,             1'b0, 1'b0);
        plan_item(CMD_CHECK,  {16'd2, 16'd2},            1'b0, 1'b0);
        plan_item(CMD_FREE,   {GEN_INIT, 16'd2},         1'b0, 1'b0);
        plan_item(CMD_FREE,   {GEN_INIT, 16'd2},         1'b0, 1'b0);
        plan_item(CMD_CHECK,  {GEN_INIT, 16'd2},         1'b0, 1'b0);
        plan_item(CMD_ALLOC,  32'h0000_0000,             1'b0, 1'b0);
        plan_item(CMD_CHECK,  {16'd2, 16'd2},            1'b0, 1'b0);
        plan_item(CMD_FREE,   {GEN_INIT, 16'd1},         1'b0, 1'b0);
        plan_item(CMD_FREE,   {16'd2, 16'd2},            1'b0, 1'b0);
        plan_item(CMD_FREE,   {GEN_INIT, 16'd3},         1'b0, 1'b0);
        plan_item(CMD_FREE,   {GEN_INIT, 16'd1},         1'b0, 1'b0);
        plan_item(CMD_CHECK,  {GEN_INIT, 16'hffff},      1'b0, 1'b0);

        // Random phases. The first one leans hard on allocate so the table
        // fills up and runs full; later phases lean on allocate, are balanced, or
        // lean on release so the table empties again. Each phase opens with a word
        // that waits for the block to drain, and the closing phases run with
        // no idling on either side. The count starts at the 21 directed words
        // and the last phase is trimmed so the run totals 950 words.
        n    = 21;
        bias = 0;
        while (n < 950) begin
            len  = $urandom_range(40, 120);
            if (n + len > 950) len = 950 - n;
            calm = (n + len >= 850) || ($urandom_range(0, 4) == 0);
            case (bias)
                0:       alloc_pct = 75;
                1:       alloc_pct = 35;
                default: alloc_pct = 8;
            endcase
            for (int j = 0; j < len; j++) begin
                r = $urandom_range(0, 99);
                if (r < alloc_pct)       cmd = CMD_ALLOC;
                else if (r >= 97)        cmd = CMD_UNUSED;
                else if ($urandom_range(0, 1) == 0) cmd = CMD_CHECK;
                else                     cmd = CMD_FREE;
                plan_item(cmd, (cmd == CMD_ALLOC) ? 32'($urandom) : pick_handle(),
                          j == 0, calm);
            end
            n    = n + len;
            bias = $urandom_range(0, 2);
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request word to be taken, then for the responses,
        // then a little longer to catch anything extra the block sends.
        while (cmd_q.size() > 0 || i_in_valid) @(posedge i_clk);
        wait_cnt = 0;
        while (due_rsp_q.size() > 0 && wait_cnt < 5000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (20) @(posedge i_clk);
        if (due_rsp_q.size() != 0) begin
            $error("%0d predicted response words never arrived", due_rsp_q.size());
            err_cnt++;
        end

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/ght_pkg.sv
rtl/ght_ram.sv
rtl/generational_handle_table_top.sv
dv/testbench.sv
